[hw/rtl/i2cbb_pkg.sv]
`timescale 1ns / 1ps

package i2cbb_pkg;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_WRITE     = 3'd3,
    ACT_READ_ACK  = 3'd4,
    ACT_READ_NACK = 3'd5,
    ACT_REG_WRITE = 3'd6,
    ACT_REG_READ  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_STOP,
    PH_WDATA,
    PH_WDEVW,
    PH_WREG,
    PH_WDEVR,
    PH_WAIT,
    PH_READ,
    PH_ACK,
    PH_NACK
  } phase_t;

  typedef struct packed {
    action_t     act;
    logic        starts;
    logic [7:0]  dev;
    logic [7:0]  reg_byte;
    logic [7:0]  data;
    logic        sda;
  } req_item_t;

  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;
  localparam logic [3:0] LAST_BIT     = 4'd7;

  function automatic logic [3:0] plan_len(action_t cmd);
    logic [3:0] n;
    unique case (cmd)
      ACT_TICK:      n = 4'd0;
      ACT_START:     n = 4'd1;
      ACT_STOP:      n = 4'd1;
      ACT_WRITE:     n = 4'd2;
      ACT_READ_ACK:  n = 4'd2;
      ACT_READ_NACK: n = 4'd2;
      ACT_REG_WRITE: n = 4'd8;
      ACT_REG_READ:  n = 4'd11;
    endcase
    return n;
  endfunction

  function automatic phase_t plan_phase(action_t cmd, logic [3:0] idx);
    phase_t ph;
    ph = PH_IDLE;
    unique case (cmd)
      ACT_TICK:  ph = PH_IDLE;
      ACT_START: ph = PH_START;
      ACT_STOP:  ph = PH_STOP;
      ACT_WRITE: ph = (idx == 4'd0) ? PH_WDATA : PH_WAIT;
      ACT_READ_ACK: ph = (idx == 4'd0) ? PH_READ : PH_ACK;
      ACT_READ_NACK: ph = (idx == 4'd0) ? PH_READ : PH_NACK;
      ACT_REG_WRITE: begin
        unique case (idx)
          4'd0:    ph = PH_START;
          4'd1:    ph = PH_WDEVW;
          4'd3:    ph = PH_WREG;
          4'd5:    ph = PH_WDATA;
          4'd7:    ph = PH_STOP;
          default: ph = PH_WAIT;
        endcase
      end
      ACT_REG_READ: begin
        unique case (idx)
          4'd0:    ph = PH_START;
          4'd1:    ph = PH_WDEVW;
          4'd3:    ph = PH_WREG;
          4'd5:    ph = PH_START;
          4'd6:    ph = PH_WDEVR;
          4'd8:    ph = PH_READ;
          4'd9:    ph = PH_NACK;
          4'd10:   ph = PH_STOP;
          default: ph = PH_WAIT;
        endcase
      end
    endcase
    return ph;
  endfunction

  function automatic logic [7:0] load_shift(phase_t ph, logic [7:0] dev,
                                            logic [7:0] reg_byte, logic [7:0] data,
                                            logic [7:0] old);
    logic [7:0] v;
    unique case (ph)
      PH_WDATA: v = data;
      PH_WDEVW: v = dev & ADDR_WR_MASK;
      PH_WREG:  v = reg_byte;
      PH_WDEVR: v = dev | ADDR_RD_BIT;
      PH_READ:  v = 8'h00;
      default:  v = old;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/i2cbb_if.sv]
`timescale 1ns / 1ps

interface i2cbb_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] device_address;
  logic [7:0] register_address;
  logic [7:0] data_byte;
  logic       sda_in;

  modport source (output valid, action, device_address, register_address, data_byte,
                  sda_in, input ready);
  modport sink (input valid, action, device_address, register_address, data_byte,
                sda_in, output ready);
endinterface

interface i2cbb_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_seen;

  modport source (output valid, scl, sda_out, busy_res, done_res, read_data, nack_seen,
                  input ready);
  modport sink (input valid, scl, sda_out, busy_res, done_res, read_data, nack_seen,
                output ready);
endinterface

[hw/rtl/i2cbb_front.sv]
`timescale 1ns / 1ps

module i2cbb_front (
  input  logic                 clk,
  input  logic                 rst,
  i2cbb_req_if.sink            req,
  output i2cbb_pkg::req_item_t q_item,
  output logic                 q_valid,
  input  logic                 pop
);

  i2cbb_pkg::req_item_t entries [2];
  i2cbb_pkg::req_item_t in_item;
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != 2'd0);
  assign q_item    = entries[rd_ptr];

  always_comb begin
    in_item.act      = i2cbb_pkg::action_t'(req.action);
    in_item.starts   = (in_item.act != i2cbb_pkg::ACT_TICK);
    in_item.dev      = req.device_address;
    in_item.reg_byte = req.register_address;
    in_item.data     = req.data_byte;
    in_item.sda      = req.sda_in;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/i2cbb_back.sv]
`timescale 1ns / 1ps

module i2cbb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cbb_pkg::req_item_t q_item,
  input  logic                 q_valid,
  output logic                 pop,
  i2cbb_res_if.source          res
);

  i2cbb_pkg::phase_t  phase, phase_next;
  i2cbb_pkg::action_t cmd, cmd_next;
  logic [3:0] idx, idx_next;
  logic [1:0] slot, slot_next;
  logic [3:0] bit_cnt, bit_cnt_next;
  logic [7:0] shift, shift_next;
  logic [7:0] dev, dev_next;
  logic [7:0] reg_byte, reg_byte_next;
  logic [7:0] data, data_next;
  logic [7:0] rx, rx_next;
  logic       nack, nack_next;
  logic       scl_lvl, scl_lvl_next;
  logic       sda_lvl, sda_lvl_next;
  logic       done_next;
  logic       out_valid;
  logic       out_done;

  assign pop = q_valid && (!out_valid || res.ready);

  always_comb begin
    i2cbb_pkg::phase_t cur;
    logic fin;
    logic rel;
    logic hold;

    cmd_next      = cmd;
    dev_next      = dev;
    reg_byte_next = reg_byte;
    data_next     = data;
    idx_next      = idx;
    slot_next     = slot;
    bit_cnt_next  = bit_cnt;
    shift_next    = shift;
    rx_next       = rx;
    nack_next     = nack;
    scl_lvl_next  = scl_lvl;
    sda_lvl_next  = sda_lvl;
    done_next     = 1'b0;
    fin           = 1'b0;
    rel           = 1'b0;
    hold          = 1'b0;
    cur           = phase;

    if (phase == i2cbb_pkg::PH_IDLE && q_item.starts) begin
      cmd_next      = q_item.act;
      dev_next      = q_item.dev;
      reg_byte_next = q_item.reg_byte;
      data_next     = q_item.data;
      nack_next     = 1'b0;
      idx_next      = 4'd0;
      slot_next     = 2'd0;
      bit_cnt_next  = 4'd0;
      cur           = i2cbb_pkg::plan_phase(q_item.act, 4'd0);
      shift_next    = i2cbb_pkg::load_shift(cur, q_item.dev, q_item.reg_byte,
                                            q_item.data, shift);
    end

    unique case (cur)
      i2cbb_pkg::PH_IDLE: begin
        hold = 1'b1;
      end
      i2cbb_pkg::PH_START: begin
        scl_lvl_next = (slot_next < 2'd2);
        sda_lvl_next = (slot_next == 2'd0);
        fin          = (slot_next >= 2'd2);
      end
      i2cbb_pkg::PH_STOP: begin
        scl_lvl_next = 1'b1;
        sda_lvl_next = (slot_next != 2'd0);
        fin          = (slot_next >= 2'd1);
      end
      i2cbb_pkg::PH_WDATA, i2cbb_pkg::PH_WDEVW, i2cbb_pkg::PH_WREG,
      i2cbb_pkg::PH_WDEVR: begin
        scl_lvl_next = (slot_next == 2'd1);
        sda_lvl_next = shift_next[7];
        if (slot_next >= 2'd2) begin
          if (bit_cnt_next >= i2cbb_pkg::LAST_BIT) begin
            sda_lvl_next = 1'b1;
            fin          = 1'b1;
          end
          shift_next   = {shift_next[6:0], 1'b0};
          bit_cnt_next = bit_cnt_next + 4'd1;
          slot_next    = 2'd0;
          hold         = 1'b1;
        end
      end
      i2cbb_pkg::PH_WAIT: begin
        scl_lvl_next = (slot_next == 2'd1);
        sda_lvl_next = 1'b1;
        if (slot_next == 2'd1 && q_item.sda) begin
          nack_next = 1'b1;
        end
        fin = (slot_next >= 2'd2);
      end
      i2cbb_pkg::PH_READ: begin
        sda_lvl_next = 1'b1;
        if (slot_next == 2'd0) begin
          scl_lvl_next = 1'b1;
          shift_next   = {shift_next[6:0], q_item.sda};
        end else begin
          scl_lvl_next = 1'b0;
          if (bit_cnt_next >= i2cbb_pkg::LAST_BIT) begin
            rx_next = shift_next;
            fin     = 1'b1;
          end else begin
            bit_cnt_next = bit_cnt_next + 4'd1;
            slot_next    = 2'd0;
            hold         = 1'b1;
          end
        end
      end
      i2cbb_pkg::PH_ACK: begin
        scl_lvl_next = (slot_next == 2'd1);
        sda_lvl_next = 1'b0;
        fin          = (slot_next >= 2'd2);
        rel          = fin;
      end
      i2cbb_pkg::PH_NACK: begin
        scl_lvl_next = (slot_next == 2'd1);
        sda_lvl_next = 1'b1;
        fin          = (slot_next >= 2'd2);
      end
      default: begin
        hold = 1'b1;
      end
    endcase

    phase_next = cur;
    if (fin) begin
      if (rel) begin
        sda_lvl_next = 1'b1;
      end
      if ((idx_next + 4'd1) < i2cbb_pkg::plan_len(cmd_next)) begin
        idx_next   = idx_next + 4'd1;
        phase_next = i2cbb_pkg::plan_phase(cmd_next, idx_next);
        shift_next = i2cbb_pkg::load_shift(phase_next, dev_next, reg_byte_next,
                                           data_next, shift_next);
      end else begin
        phase_next = i2cbb_pkg::PH_IDLE;
        idx_next   = 4'd0;
        done_next  = 1'b1;
      end
      slot_next    = 2'd0;
      bit_cnt_next = 4'd0;
    end else if (!hold) begin
      slot_next = slot_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= i2cbb_pkg::PH_IDLE;
      idx     <= 4'd0;
      slot    <= 2'd0;
      bit_cnt <= 4'd0;
      scl_lvl <= 1'b1;
      sda_lvl <= 1'b1;
      nack    <= 1'b0;
      rx      <= 8'h00;
      cmd     <= i2cbb_pkg::ACT_TICK;
      shift   <= 8'h00;
    end else if (pop) begin
      phase   <= phase_next;
      idx     <= idx_next;
      slot    <= slot_next;
      bit_cnt <= bit_cnt_next;
      scl_lvl <= scl_lvl_next;
      sda_lvl <= sda_lvl_next;
      nack    <= nack_next;
      rx      <= rx_next;
      cmd     <= cmd_next;
      shift   <= shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dev      <= dev_next;
      reg_byte <= reg_byte_next;
      data     <= data_next;
      out_done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields come straight from the updated bus state
  assign res.valid     = out_valid;
  assign res.scl       = scl_lvl;
  assign res.sda_out   = sda_lvl;
  assign res.busy_res  = (phase != i2cbb_pkg::PH_IDLE);
  assign res.done_res  = out_done;
  assign res.read_data = rx;
  assign res.nack_seen = nack;

endmodule

[hw/rtl/i2c_bitbang_master.sv]
`timescale 1ns / 1ps

// Channel  Role    Payload
// req      sink    action, device_address, register_address, data_byte, sda_in
// res      source  scl, sda_out, busy_res, done_res, read_data, nack_seen
//
// One request per clock sustained while the result is not stalled; one result per request.
// A request passes through the two-entry request queue, then the bus state
// and result register, which advance together on each request taken from the queue.
// rst is synchronous: lines released, sequencer idle, queue empty.
// A stalled result holds the sequencer; the queue keeps taking requests
// until both entries are full.

module i2c_bitbang_master (
  input  logic        clk,
  input  logic        rst,
  i2cbb_req_if.sink   req,
  i2cbb_res_if.source res
);

  i2cbb_pkg::req_item_t q_item;
  logic                 q_valid;
  logic                 pop;

  i2cbb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_item  (q_item),
    .q_valid (q_valid),
    .pop     (pop)
  );

  i2cbb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .pop     (pop),
    .res     (res)
  );

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty request queue");

  a_pop_fills_out: assert property (@(posedge clk) disable iff (rst)
    pop |=> res.valid)
    else $error("popped request produced no result");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !pop)
    else $error("sequencer advanced while result stalled");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.done_res && res.busy_res))
    else $error("done and busy in the same slot");

endmodule
